@@ rtl/splg_pkg.sv @@
`timescale 1ns / 1ps
package splg_pkg;

   localparam int LINE_WIDTH   = 240;
   localparam int FRAME_HEIGHT = 240;
   localparam int GRAD_DIV     = (FRAME_HEIGHT > 1) ? FRAME_HEIGHT - 1 : 1;

   // Gradient divide by reciprocal: floor(v / GRAD_DIV) = (v * GRAD_M) >> GRAD_K, v <= 65025
   localparam int     GRAD_K = 25;
   localparam longint GRAD_M = ((longint'(1) << GRAD_K) + GRAD_DIV - 1) / GRAD_DIV;

   // Ellipse terms by reciprocal: floor(sq*10000/R^2) = (sq * M) >> K for sq <= 65025
   // 10000/45^2 = 400/81, 10000/115^2 = 400/529, 10000/30^2 = 100/9, 10000/100^2 = 1
   localparam int     ELL_K45  = 23;
   localparam longint ELL_M45  = ((longint'(400) << ELL_K45) + 80) / 81;
   localparam int     ELL_K115 = 26;
   localparam longint ELL_M115 = ((longint'(400) << ELL_K115) + 528) / 529;
   localparam int     ELL_K30  = 20;
   localparam longint ELL_M30  = ((longint'(100) << ELL_K30) + 8) / 9;

   // Fixed colors, RGB565
   localparam logic [15:0] COLOR_TOP     = 16'hD943;
   localparam logic [15:0] COLOR_BOTTOM  = 16'hA083;
   localparam logic [15:0] COLOR_DARK    = 16'h7062;
   localparam logic [15:0] COLOR_GOLD    = 16'hFE25;
   localparam logic [15:0] COLOR_GOLD_HI = 16'hFF0C;
   localparam logic [15:0] COLOR_GOLD_LO = 16'hC380;

   localparam logic [7:0] T_VIGNETTE  = 8'd58;
   localparam logic [7:0] T_GLOW      = 8'd54;
   localparam logic [7:0] T_SHADOW    = 8'd150;
   localparam logic [7:0] T_HILITE    = 8'd68;
   localparam logic [7:0] T_SHADE     = 8'd48;

   // Squared distances of one point to the arch centers, plus leg hit
   typedef struct packed {
      logic        arch_ok;   // row at or above the arch center, point live
      logic        leg;       // inside one of the four legs, point live
      logic [15:0] dxl_sq;    // to the left arch column
      logic [15:0] dxr_sq;    // to the right arch column
      logic [15:0] dy_sq;     // to the arch center row
   } point_type;

   // Gradient blend factor for each row, saturated at 255
   function automatic logic [7:0] grad_t(input logic [7:0] y);
      logic [39:0] p;
      logic [14:0] q;
      p = 40'(y) * 40'(255 * GRAD_M);
      q = 15'(p >> GRAD_K);
      return (q > 15'd255) ? 8'd255 : q[7:0];
   endfunction

   // Ellipse metric term from a squared distance
   function automatic logic [23:0] ell_term(input logic [15:0] sq, input longint m,
                                            input int k);
      logic [47:0] p;
      p = 48'(sq) * 48'(m);
      return 24'(p >> k);
   endfunction

   function automatic logic in_box(input logic [7:0] x, input logic [7:0] y,
                                   input int l, input int r);
      return int'(x) >= l && int'(x) < r && y >= 8'd164 && y < 8'd200;
   endfunction

   // First half of the shape test: distances and legs
   function automatic point_type logo_point(input logic [7:0] x, input logic [7:0] y,
                                            input logic live);
      point_type  p;
      logic [7:0] dxl, dxr, dy;
      dxl = (x >= 8'd91)  ? x - 8'd91  : 8'd91 - x;
      dxr = (x >= 8'd149) ? x - 8'd149 : 8'd149 - x;
      dy  = 8'd178 - y;
      p.arch_ok = live && y <= 8'd178;
      p.leg     = live && (in_box(x, y, 46, 62) || in_box(x, y, 102, 118) ||
                           in_box(x, y, 122, 138) || in_box(x, y, 178, 194));
      p.dxl_sq  = 16'(dxl) * 16'(dxl);
      p.dxr_sq  = 16'(dxr) * 16'(dxr);
      p.dy_sq   = 16'(dy) * 16'(dy);
      return p;
   endfunction

   // Ring test: outer metric <= 10000 and inner metric >= 10000
   function automatic logic ring_hit(input logic [15:0] dx_sq, input logic [15:0] dy_sq);
      logic [24:0] outer, inner;
      outer = 25'(ell_term(dx_sq, ELL_M45, ELL_K45)) +
              25'(ell_term(dy_sq, ELL_M115, ELL_K115));
      inner = 25'(ell_term(dx_sq, ELL_M30, ELL_K30)) + 25'(dy_sq);
      return (outer <= 25'd10000) && (inner >= 25'd10000);
   endfunction

   // Second half of the shape test
   function automatic logic logo_hit(input point_type p);
      return (p.arch_ok && (ring_hit(p.dxl_sq, p.dy_sq) || ring_hit(p.dxr_sq, p.dy_sq))) ||
             p.leg;
   endfunction

   function automatic logic in_disc(input logic [7:0] x, input logic [7:0] y,
                                    input int cx, input int cy, input int r);
      int dx, dy;
      dx = int'(x) - cx;
      dy = int'(y) - cy;
      return dx * dx + dy * dy <= r * r;
   endfunction

   // Intermediate shape data between the two geometry stages
   typedef struct packed {
      logic      outside;
      logic      glow;
      logic      hilite;
      logic      shade;
      point_type shadow_pt;
      point_type logo_pt;
   } probe_type;

   // Per-pixel decisions handed to the blend stages
   typedef struct packed {
      logic       outside;
      logic       glow;
      logic       shadow;
      logic       logo;
      logic       hilite;
      logic       shade;
   } flags_type;

endpackage

@@ rtl/splash_logo_pixel_generator.sv @@
`timescale 1ns / 1ps
// Throughput: one pixel per cycle; a stall on rsp freezes the whole pipeline.
// Stages: shape distances, shape tests, gradient, vignette, glow, shadow,
// gold highlight, gold shade.
// Reset clears valid bits only; the data registers are not reset.
module splash_logo_pixel_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] pixel_column, [15:8] pixel_row
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [15:0] pixel_word
);
   import splg_pkg::*;

   logic enable;
   assign enable     = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;

   // Stage 1: discs, legs, squared arch distances and gradient factor
   logic        s1_valid_ff;
   probe_type   s1_probe_ff, s1_probe_in;
   logic [7:0]  s1_t_ff;
   always_comb begin
      logic [7:0] x, y;
      logic       shadow_live;
      x = req_tdata[7:0];
      y = req_tdata[15:8];
      shadow_live = x >= 8'd4 && y >= 8'd5;
      s1_probe_in.outside   = !in_disc(x, y, 120, 120, 116);
      s1_probe_in.glow      = in_disc(x, y, 120, 105, 82);
      s1_probe_in.hilite    = x < 8'd74 || (x >= 8'd122 && x < 8'd136);
      s1_probe_in.shade     = y > 8'd172;
      s1_probe_in.shadow_pt = logo_point(x - 8'd4, y - 8'd5, shadow_live);
      s1_probe_in.logo_pt   = logo_point(x, y, 1'b1);
   end
   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (enable) s1_valid_ff <= req_tvalid;
      if (enable) begin
         s1_probe_ff <= s1_probe_in;
         s1_t_ff     <= grad_t(req_tdata[15:8]);
      end
   end

   // Stage 2: ellipse ring tests
   logic        s2_valid_ff;
   flags_type   s2_flags_ff, s2_flags_in;
   logic [7:0]  s2_t_ff;
   always_comb begin
      s2_flags_in.outside = s1_probe_ff.outside;
      s2_flags_in.glow    = s1_probe_ff.glow;
      s2_flags_in.shadow  = logo_hit(s1_probe_ff.shadow_pt);
      s2_flags_in.logo    = logo_hit(s1_probe_ff.logo_pt);
      s2_flags_in.hilite  = s1_probe_ff.hilite;
      s2_flags_in.shade   = s1_probe_ff.shade;
   end
   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (enable) s2_valid_ff <= s1_valid_ff;
      if (enable) begin
         s2_flags_ff <= s2_flags_in;
         s2_t_ff     <= s1_t_ff;
      end
   end

   // Flags travel alongside the blend chain
   flags_type f2_ff, f3_ff, f4_ff, f5_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         f2_ff <= s2_flags_ff;
         f3_ff <= f2_ff;
         f4_ff <= f3_ff;
         f5_ff <= f4_ff;
      end
   end

   logic        v2, v3, v4, v5, v6, v7;
   logic [15:0] c2, c3, c4, c5, c6, c7;

   splg_blend u_grad (.clock, .reset, .enable, .valid_in(s2_valid_ff), .apply(1'b1),
      .color_a(COLOR_TOP), .color_b(COLOR_BOTTOM), .weight(s2_t_ff),
      .valid_out(v2), .color_out(c2));
   splg_blend u_vig (.clock, .reset, .enable, .valid_in(v2), .apply(f2_ff.outside),
      .color_a(c2), .color_b(COLOR_DARK), .weight(T_VIGNETTE),
      .valid_out(v3), .color_out(c3));
   splg_blend u_glow (.clock, .reset, .enable, .valid_in(v3), .apply(f3_ff.glow),
      .color_a(c3), .color_b(COLOR_TOP), .weight(T_GLOW),
      .valid_out(v4), .color_out(c4));
   splg_blend u_shadow (.clock, .reset, .enable, .valid_in(v4), .apply(f4_ff.shadow),
      .color_a(c4), .color_b(COLOR_DARK), .weight(T_SHADOW),
      .valid_out(v5), .color_out(c5));

   // Gold fill: base gold replaces the background, then highlight
   logic [15:0] gold_a;
   assign gold_a = f5_ff.logo ? COLOR_GOLD : c5;
   splg_blend u_hi (.clock, .reset, .enable, .valid_in(v5),
      .apply(f5_ff.logo && f5_ff.hilite),
      .color_a(gold_a), .color_b(COLOR_GOLD_HI), .weight(T_HILITE),
      .valid_out(v6), .color_out(c6));
   flags_type f6_ff;
   always_ff @(posedge clock) if (enable) f6_ff <= f5_ff;
   splg_blend u_lo (.clock, .reset, .enable, .valid_in(v6),
      .apply(f6_ff.logo && f6_ff.shade),
      .color_a(c6), .color_b(COLOR_GOLD_LO), .weight(T_SHADE),
      .valid_out(v7), .color_out(c7));

   assign rsp_tvalid = v7;
   assign rsp_tdata  = {c7[7:0], c7[15:8]};

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed during stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready mismatch");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      enable && !v6 |=> !rsp_tvalid)
      else $error("result without item");
endmodule

@@ rtl/splg_blend.sv @@
`timescale 1ns / 1ps
// One registered blend stage: c = a*(255-t)+b*t per channel, /255, repack; a passes through when apply is low
module splg_blend (
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  logic        valid_in,
   input  logic        apply,
   input  logic [15:0] color_a,
   input  logic [15:0] color_b,
   input  logic [7:0]  weight,
   output logic        valid_out,
   output logic [15:0] color_out
);
   import splg_pkg::*;

   logic        valid_ff;
   logic [15:0] color_ff, color_in;

   // Divide a 16-bit sum by 255 with truncation
   function automatic logic [7:0] div255(input logic [15:0] s);
      logic [16:0] q;
      q = (17'(s) + 17'd1 + 17'(s >> 8)) >> 8;
      return q[7:0];
   endfunction

   always_comb begin
      logic [7:0]  ar, ag, ab, br, bg, bb, inv, r, g, b;
      inv = 8'd255 - weight;
      ar = {color_a[15:11], 3'b0};
      ag = {color_a[10:5], 2'b0};
      ab = {color_a[4:0], 3'b0};
      br = {color_b[15:11], 3'b0};
      bg = {color_b[10:5], 2'b0};
      bb = {color_b[4:0], 3'b0};
      r = div255(16'(ar * inv) + 16'(br * weight));
      g = div255(16'(ag * inv) + 16'(bg * weight));
      b = div255(16'(ab * inv) + 16'(bb * weight));
      color_in = apply ? {r[7:3], g[7:2], b[7:3]} : color_a;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) color_ff <= color_in;
   end

   assign valid_out = valid_ff;
   assign color_out = color_ff;
endmodule

@@ tb/sv/splash_logo_pixel_generator_tb.sv @@
`timescale 1ns / 1ps
module splash_logo_pixel_generator_tb;
   import splg_pkg::*;

   localparam int RANDOM_PIXELS = 1300;
   localparam int PIPE_LATENCY  = 7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   logic [15:0] pending_words[$];
   int          mismatch_count = 0;
   int          hold_cycles = 0;
   bit          feeding_done = 1'b0;
   bit          rsp_taken = 1'b0;
   int          rsp_wait = 0;

   splash_logo_pixel_generator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // Shaping helpers, all plain integer math
   function automatic logic [15:0] pack_rgb(int unsigned r, int unsigned g, int unsigned b);
      return 16'(((r & 'hF8) << 8) | ((g & 'hFC) << 3) | ((b & 'hFF) >> 3));
   endfunction

   function automatic logic [15:0] blend(logic [15:0] a, logic [15:0] b, int unsigned t);
      int unsigned inv, ar, ag, ab, br, bg, bb;
      inv = 255 - t;
      ar = int'(a[15:11]) << 3; ag = int'(a[10:5]) << 2; ab = int'(a[4:0]) << 3;
      br = int'(b[15:11]) << 3; bg = int'(b[10:5]) << 2; bb = int'(b[4:0]) << 3;
      return pack_rgb((ar * inv + br * t) / 255, (ag * inv + bg * t) / 255,
                      (ab * inv + bb * t) / 255);
   endfunction

   function automatic bit disc_hit(int x, int y, int cx, int cy, int r);
      return (x - cx) * (x - cx) + (y - cy) * (y - cy) <= r * r;
   endfunction

   function automatic longint oval(int x, int y, int cx, int rx, int ry);
      longint dx, dy;
      dx = x - cx;
      dy = y - 178;
      return (dx * dx * 10000) / (rx * rx) + (dy * dy * 10000) / (ry * ry);
   endfunction

   function automatic bit arch_hit(int x, int y, int cx);
      if (y > 178) return 1'b0;
      return oval(x, y, cx, 45, 115) <= 10000 && oval(x, y, cx, 30, 100) >= 10000;
   endfunction

   function automatic bit leg_hit(int x, int y, int l);
      return x >= l && x < l + 16 && y >= 164 && y < 200;
   endfunction

   function automatic bit logo_hit(int x, int y);
      return arch_hit(x, y, 91) || arch_hit(x, y, 149) || leg_hit(x, y, 46) ||
             leg_hit(x, y, 102) || leg_hit(x, y, 122) || leg_hit(x, y, 178);
   endfunction

   // Expected panel word for one coordinate
   function automatic logic [15:0] logo_pixel(logic [7:0] col, logic [7:0] row);
      int          x, y;
      int unsigned t;
      logic [15:0] c, top, dark;
      x = col;
      y = row;
      top  = pack_rgb(218, 41, 28);
      dark = pack_rgb(116, 15, 22);
      t = (y * 255) / ((FRAME_HEIGHT > 1) ? FRAME_HEIGHT - 1 : 1);
      if (t > 255) t = 255;
      c = blend(top, pack_rgb(166, 18, 26), t);
      if (!disc_hit(x, y, 120, 120, 116)) c = blend(c, dark, T_VIGNETTE);
      if (disc_hit(x, y, 120, 105, 82)) c = blend(c, top, T_GLOW);
      if (x >= 4 && y >= 5 && logo_hit(x - 4, y - 5)) c = blend(c, dark, T_SHADOW);
      if (logo_hit(x, y)) begin
         c = pack_rgb(255, 199, 44);
         if (x < 74 || (x >= 122 && x < 136)) c = blend(c, pack_rgb(255, 224, 96), T_HILITE);
         if (y > 172) c = blend(c, pack_rgb(194, 113, 0), T_SHADE);
      end
      return {c[7:0], c[15:8]};
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      mismatch_count++;
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
   endtask

   // Send one coordinate; expectation is queued at the transfer edge
   task automatic send_pixel(logic [7:0] col, logic [7:0] row, int fixed_word);
      int gap;
      gap = $urandom_range(0, 17);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {row, col};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (fixed_word >= 0 && 16'(fixed_word) != logo_pixel(col, row))
         report_mismatch("table", logo_pixel(col, row), 16'(fixed_word));
      pending_words.push_back(logo_pixel(col, row));
      @(negedge clock);
   endtask

   // Directed table: {column, row, expected or -1}
   typedef struct {
      logic [7:0] col;
      logic [7:0] row;
      int         word;
   } corner_row;

   corner_row corners[] = '{
      '{8'd0, 8'd0, -1}, '{8'd255, 8'd0, -1}, '{8'd0, 8'd255, -1},
      '{8'd255, 8'd255, -1}, '{8'd120, 8'd120, -1}, '{8'd239, 8'd239, -1},
      '{8'd240, 8'd100, -1}, '{8'd100, 8'd240, -1}, '{8'd3, 8'd200, -1},
      '{8'd60, 8'd4, -1}, '{8'd50, 8'd170, -1}, '{8'd50, 8'd180, -1},
      '{8'd125, 8'd165, -1}, '{8'd140, 8'd170, -1}, '{8'd91, 8'd64, -1},
      '{8'd149, 8'd70, -1}, '{8'd110, 8'd175, -1}, '{8'd185, 8'd190, -1},
      '{8'd120, 8'd105, -1}, '{8'd170, 8'd85, -1}, '{8'd66, 8'd205, -1},
      '{8'd170, 8'd55, -1}, '{8'd110, 8'd168, 16'h25FE}
   };

   initial begin
      int n;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (corners[i]) send_pixel(corners[i].col, corners[i].row, corners[i].word);
      for (n = 0; n < RANDOM_PIXELS; n++) begin
         if (n == 400) begin
            // drain completely before continuing
            req_tvalid <= 1'b0;
            while (pending_words.size() != 0) @(negedge clock);
         end
         if (n == 700) hold_cycles = 60;
         if ($urandom_range(0, 2) == 0)
            send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), -1);
         else
            send_pixel(8'($urandom_range(30, 210)), 8'($urandom_range(50, 205)), -1);
      end
      req_tvalid <= 1'b0;
      feeding_done = 1'b1;
   end

   // Receiver: a wait drawn per transfer plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else if (rsp_taken) begin
         rsp_taken = 1'b0;
         rsp_wait  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
         rsp_tready <= (rsp_wait == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_tready <= (rsp_wait == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare every transfer against the oldest expected word
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_taken = 1'b1;
         if (pending_words.size() == 0)
            report_mismatch("unexpected", rsp_tdata, 16'h0);
         else if (rsp_tdata != pending_words[0])
            report_mismatch("pixel_word", rsp_tdata, pending_words.pop_front());
         else
            void'(pending_words.pop_front());
      end
   end

   initial begin
      wait (feeding_done);
      while (pending_words.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY * 4) @(posedge clock);
      if (mismatch_count == 0 && pending_words.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #2ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ files.f @@
rtl/splg_pkg.sv
rtl/splg_blend.sv
rtl/splash_logo_pixel_generator.sv
tb/sv/splash_logo_pixel_generator_tb.sv
